/* sv/kmcd_pkg.sv */
`timescale 1ns / 1ps
// kmcd_pkg: shared types, constants and keymap table for the key matrix change detector
// no dependencies; imported by kmcd_ctrl, kmcd_datapath, key_matrix_change_detector_core and the testbench

package kmcd_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = 5;

  typedef struct packed {
    logic [2:0]  column_index;
    logic [15:0] row_levels;
  } kmcd_in_t;

  typedef struct packed {
    logic [7:0] keycode;
    logic       is_press;
    logic       last_event;
  } kmcd_out_t;

  typedef enum logic {
    KMCD_IDLE,
    KMCD_SCAN
  } kmcd_state_e;

  typedef struct packed {
    logic load;
    logic step;
  } kmcd_cmd_t;

  typedef struct packed {
    logic col_ok;
    logic row_last;
    logic stall;
  } kmcd_status_t;

  // 16 rows x 8 columns, row-major
  localparam logic [7:0] KEYMAP [128] = '{
      8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd0,   8'd0,   8'd57,
      8'd2,   8'd16,  8'd30,  8'd44,  8'd59,  8'd0,   8'd0,   8'd41,
      8'd3,   8'd17,  8'd31,  8'd45,  8'd60,  8'd0,   8'd0,   8'd0,
      8'd4,   8'd18,  8'd32,  8'd46,  8'd61,  8'd0,   8'd0,   8'd0,
      8'd5,   8'd19,  8'd33,  8'd47,  8'd62,  8'd0,   8'd0,   8'd0,
      8'd6,   8'd20,  8'd34,  8'd48,  8'd63,  8'd0,   8'd0,   8'd0,
      8'd7,   8'd21,  8'd35,  8'd49,  8'd64,  8'd0,   8'd0,   8'd0,
      8'd8,   8'd22,  8'd36,  8'd50,  8'd65,  8'd0,   8'd0,   8'd0,
      8'd9,   8'd23,  8'd37,  8'd51,  8'd66,  8'd0,   8'd0,   8'd105,
      8'd10,  8'd24,  8'd38,  8'd52,  8'd67,  8'd27,  8'd0,   8'd108,
      8'd11,  8'd25,  8'd39,  8'd53,  8'd68,  8'd43,  8'd0,   8'd28,
      8'd12,  8'd26,  8'd40,  8'd103, 8'd87,  8'd28,  8'd14,  8'd106,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd42,  8'd0,   8'd54,  8'd0,
      8'd0,   8'd125, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd29,  8'd0,   8'd0,   8'd183, 8'd0,   8'd0,   8'd0,   8'd126,
      8'd0,   8'd0,   8'd100, 8'd0,   8'd0,   8'd56,  8'd0,   8'd0
  };

  // rows past the table map to zero (unmapped)
  function automatic logic [7:0] kmcd_keycode(input logic [4:0] row, input logic [2:0] col);
    logic [7:0] code;
    code = 8'h00;
    if (!row[4]) begin
      code = KEYMAP[{row[3:0], col}];
    end
    return code;
  endfunction

endpackage

/* sv/kmcd_ctrl.sv */
`timescale 1ns / 1ps
// kmcd_ctrl: idle/scan state machine that sequences one row per step
// depends on kmcd_pkg for the state enum and command/status structs

module kmcd_ctrl import kmcd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  kmcd_status_t status_i,
  output kmcd_cmd_t    cmd_o
);

  kmcd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= KMCD_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      KMCD_IDLE: begin
        if (in_valid_i && status_i.col_ok) begin
          state_d = KMCD_SCAN;
        end
      end
      KMCD_SCAN: begin
        if (!status_i.stall && status_i.row_last) begin
          state_d = KMCD_IDLE;
        end
      end
      default: state_d = KMCD_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      KMCD_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i && status_i.col_ok;
      end
      KMCD_SCAN: begin
        cmd_o.step = !status_i.stall;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == KMCD_SCAN && cmd_o.step && status_i.row_last) |=> state_q == KMCD_IDLE)
    else $error("scan did not end after last row");

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == KMCD_SCAN && !in_ready_o))
    else $error("accepted sample did not start a scan");

endmodule

/* sv/kmcd_datapath.sv */
`timescale 1ns / 1ps
// kmcd_datapath: sample registers, pressed map, row counter, event counter and output register
// depends on kmcd_pkg for payload structs, command/status structs and the keymap function

module kmcd_datapath import kmcd_pkg::*; #(
  parameter int ROWS = 16,
  parameter int COLS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  kmcd_in_t     in_i,
  input  kmcd_cmd_t    cmd_i,
  output kmcd_status_t status_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output kmcd_out_t    out_o
);

  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CIDX_W = (COLS > 1) ? $clog2(COLS) : 1;

  logic [2:0]       col_q;
  logic [15:0]      levels_q;
  logic [ROW_W-1:0] row_q;
  logic [CNT_W-1:0] cnt_q;
  logic [COLS-1:0]  map_q [ROWS];
  logic             out_valid_q;
  kmcd_out_t        out_q;

  logic [CIDX_W-1:0] col_idx;
  logic [31:0]       lvl_ext;
  logic [ROWS-1:0]   now_vec;
  logic [ROWS-1:0]   later_vec;
  logic              now_cur;
  logic              changed;
  logic [7:0]        code_cur;
  logic              emit_req;
  logic              emit;

  assign col_idx = CIDX_W'(col_q);
  // rows beyond the sampled width read as released (high)
  assign lvl_ext = {16'hFFFF, levels_q};
  assign now_vec = ~lvl_ext[ROWS-1:0];

  assign now_cur  = now_vec[row_q];
  assign changed  = now_cur ^ map_q[row_q][col_idx];
  assign code_cur = kmcd_keycode(5'(row_q), col_q);
  assign emit_req = changed && (code_cur != 8'h00) && (cnt_q < CNT_W'(MAX_RESULTS));
  assign emit     = cmd_i.step && emit_req;

  // mapped changes still ahead in rows above the current one
  always_comb begin
    for (int j = 0; j < ROWS; j++) begin
      later_vec[j] = (now_vec[j] ^ map_q[j][col_idx])
                     && (kmcd_keycode(5'(j), col_q) != 8'h00)
                     && (ROW_W'(j) > row_q);
    end
  end

  assign status_o.col_ok   = {3'b000, in_i.column_index} < 6'(COLS);
  assign status_o.row_last = (row_q == ROW_W'(ROWS - 1));
  assign status_o.stall    = emit_req && out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      col_q    <= in_i.column_index;
      levels_q <= in_i.row_levels;
    end
    if (emit) begin
      out_q.keycode    <= code_cur;
      out_q.is_press   <= now_cur;
      out_q.last_event <= (cnt_q == CNT_W'(MAX_RESULTS - 1)) || !(|later_vec);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < ROWS; i++) begin
        map_q[i] <= '0;
      end
    end else begin
      if (cmd_i.load) begin
        row_q <= '0;
        cnt_q <= '0;
      end else if (cmd_i.step) begin
        row_q <= row_q + ROW_W'(1);
        if (changed) begin
          map_q[row_q][col_idx] <= now_cur;
        end
        if (emit_req) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_RESULTS))
    else $error("event count above cap");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_q)))
    else $error("held result overwritten");

  a_load_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (row_q == '0 && cnt_q == '0))
    else $error("scan counters not cleared on load");

endmodule

/* sv/key_matrix_change_detector_core.sv */
`timescale 1ns / 1ps
// key_matrix_change_detector_core: top level of the key matrix change detector
// depends on kmcd_pkg, kmcd_ctrl and kmcd_datapath

// Each input request is one column sample: the column that was driven low and the
// active-low row levels read back. The block walks the rows in ascending order, one
// row per clock, against its pressed map; every changed key updates the map, and each
// changed key with a nonzero keymap code produces an output request carrying the code,
// a press/release flag and a last-event flag on the final event of the sample (at most
// 16 events per sample, further changes are stored silently). When the output side
// holds back an event the scan pauses on that row. A sample whose column is not below
// COLS is accepted and dropped without a scan. The pressed map is cleared at reset. The
// last event of a sample can still sit in the output register while the next sample
// is accepted.

module key_matrix_change_detector_core import kmcd_pkg::*; #(
  parameter int ROWS = 16,
  parameter int COLS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  kmcd_in_t  in_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output kmcd_out_t out_o
);

  // command and status between sequencer and datapath
  kmcd_cmd_t    cmd;
  kmcd_status_t status;

  // state machine: idle waits for a sample, scan steps one row per clock unless the output stalls
  kmcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // pressed map, keymap lookup, event counting and the output register
  kmcd_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking bench for key_matrix_change_detector_core
// depends on kmcd_pkg (request and event types) and the core rtl only

module testbench;
  import kmcd_pkg::*;

  localparam int ROW_COUNT       = 16;
  localparam int COL_COUNT       = 8;
  localparam int EVENT_CAP       = 16;
  localparam int RANDOM_SAMPLES  = 450;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 40;
  localparam int CYCLE_LIMIT     = 200000;

  // when random requests reach these counts the run changes its pressure pattern
  localparam int HOLD_OFF_AT    = 120;
  localparam int DRAIN_AT       = 250;
  localparam int QUIET_FROM     = 300;
  localparam int QUIET_TO       = 380;

  // own copy of the keymap, 16 rows x 8 columns, row-major
  localparam logic [7:0] KEY_CODES [128] = '{
      8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd0,   8'd0,   8'd57,
      8'd2,   8'd16,  8'd30,  8'd44,  8'd59,  8'd0,   8'd0,   8'd41,
      8'd3,   8'd17,  8'd31,  8'd45,  8'd60,  8'd0,   8'd0,   8'd0,
      8'd4,   8'd18,  8'd32,  8'd46,  8'd61,  8'd0,   8'd0,   8'd0,
      8'd5,   8'd19,  8'd33,  8'd47,  8'd62,  8'd0,   8'd0,   8'd0,
      8'd6,   8'd20,  8'd34,  8'd48,  8'd63,  8'd0,   8'd0,   8'd0,
      8'd7,   8'd21,  8'd35,  8'd49,  8'd64,  8'd0,   8'd0,   8'd0,
      8'd8,   8'd22,  8'd36,  8'd50,  8'd65,  8'd0,   8'd0,   8'd0,
      8'd9,   8'd23,  8'd37,  8'd51,  8'd66,  8'd0,   8'd0,   8'd105,
      8'd10,  8'd24,  8'd38,  8'd52,  8'd67,  8'd27,  8'd0,   8'd108,
      8'd11,  8'd25,  8'd39,  8'd53,  8'd68,  8'd43,  8'd0,   8'd28,
      8'd12,  8'd26,  8'd40,  8'd103, 8'd87,  8'd28,  8'd14,  8'd106,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd42,  8'd0,   8'd54,  8'd0,
      8'd0,   8'd125, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd29,  8'd0,   8'd0,   8'd183, 8'd0,   8'd0,   8'd0,   8'd126,
      8'd0,   8'd0,   8'd100, 8'd0,   8'd0,   8'd56,  8'd0,   8'd0
  };

  // how a directed row is checked: by the predictor, by a typed-in single event, or as giving no event
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_ONE
  } check_kind_e;

  typedef struct packed {
    logic [2:0]  col;
    logic [15:0] levels;
    check_kind_e kind;
    logic [7:0]  code;
    logic        press;
  } scan_vector_t;

  localparam int VECTOR_COUNT = 22;

  localparam scan_vector_t SCAN_VECTORS [VECTOR_COUNT] = '{
    // nothing pressed after reset, all rows high: no events
    '{3'd0, 16'hFFFF, CHK_NONE, 8'd0,   1'b0},
    // single key row 0 column 4, press then release
    '{3'd4, 16'hFFFE, CHK_ONE,  8'd1,   1'b1},
    '{3'd4, 16'hFFFF, CHK_ONE,  8'd1,   1'b0},
    // unmapped key changes silently
    '{3'd6, 16'hFFFE, CHK_NONE, 8'd0,   1'b0},
    '{3'd6, 16'hFFFF, CHK_NONE, 8'd0,   1'b0},
    // largest keycode in the map, then the same sample again
    '{3'd3, 16'hBFFF, CHK_ONE,  8'd183, 1'b1},
    '{3'd3, 16'hBFFF, CHK_NONE, 8'd0,   1'b0},
    '{3'd3, 16'hFFFF, CHK_ONE,  8'd183, 1'b0},
    // whole column pressed and released
    '{3'd7, 16'h0000, CHK_MODEL, 8'd0, 1'b0},
    '{3'd7, 16'hFFFF, CHK_MODEL, 8'd0, 1'b0},
    // every key of the matrix down
    '{3'd0, 16'h0000, CHK_MODEL, 8'd0, 1'b0},
    '{3'd1, 16'h0000, CHK_MODEL, 8'd0, 1'b0},
    '{3'd2, 16'h0000, CHK_MODEL, 8'd0, 1'b0},
    '{3'd3, 16'h0000, CHK_MODEL, 8'd0, 1'b0},
    '{3'd4, 16'h0000, CHK_MODEL, 8'd0, 1'b0},
    '{3'd5, 16'h0000, CHK_MODEL, 8'd0, 1'b0},
    '{3'd6, 16'h0000, CHK_MODEL, 8'd0, 1'b0},
    '{3'd7, 16'h0000, CHK_MODEL, 8'd0, 1'b0},
    // mixed presses and releases in one sample
    '{3'd5, 16'hAAAA, CHK_MODEL, 8'd0, 1'b0},
    '{3'd5, 16'h5555, CHK_MODEL, 8'd0, 1'b0},
    '{3'd2, 16'h7FFF, CHK_MODEL, 8'd0, 1'b0},
    '{3'd4, 16'hFFFF, CHK_MODEL, 8'd0, 1'b0}
  };

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  kmcd_in_t  in_i        = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  kmcd_out_t out_o;

  key_matrix_change_detector_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  // predictor state: bit c of pred_pressed[r] is the key at row r, column c
  logic [COL_COUNT-1:0] pred_pressed [ROW_COUNT];
  kmcd_out_t            expected_events [$];

  // stimulus side: the simulated keyboard that the realistic scan reads
  logic [15:0] held_rows [COL_COUNT];
  int unsigned scan_col;

  // pressure controls shared between sender and receiver
  bit no_idle;
  bit hold_off_req;
  bit hold_off_done;

  int unsigned cycle_count;
  int unsigned samples_sent;
  int unsigned events_seen;
  int unsigned presses_seen;
  int unsigned releases_seen;
  int unsigned mismatches;

  // 2 ns clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // walk the rows of one column sample against the pressed map; optionally
  // queue the events that the block should emit
  function automatic void predict_key_events(input kmcd_in_t s, input bit enqueue);
    kmcd_out_t   batch [EVENT_CAP];
    int          found;
    logic        now_down;
    logic        was_down;
    logic [7:0]  code;
    int unsigned col;
    found = 0;
    col   = s.column_index;
    if (col >= COL_COUNT) begin
      return;
    end
    for (int r = 0; r < ROW_COUNT; r++) begin
      now_down = ~s.row_levels[r];
      was_down = pred_pressed[r][col];
      if (now_down != was_down) begin
        pred_pressed[r][col] = now_down;
        code = KEY_CODES[r * COL_COUNT + col];
        // unmapped keys update the map without an event; cap per sample
        if (code != 8'd0 && found < EVENT_CAP) begin
          batch[found].keycode    = code;
          batch[found].is_press   = now_down;
          batch[found].last_event = 1'b0;
          found++;
        end
      end
    end
    if (enqueue) begin
      for (int i = 0; i < found; i++) begin
        if (i == found - 1) begin
          batch[i].last_event = 1'b1;
        end
        expected_events.push_back(batch[i]);
      end
    end
  endfunction

  // offer one request and return at the edge that accepts it; valid is touched
  // at most once per time step so a back-to-back request keeps it high
  task automatic offer_sample(input kmcd_in_t s, input bit drain_first);
    int idle;
    idle = 0;
    if (!no_idle) begin
      while ($urandom_range(99, 0) < 20) begin
        idle++;
      end
    end
    if (drain_first || idle > 0) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      // sender pause: let every expected event come out first
      while (drain_first && expected_events.size() != 0) begin
        @(posedge clk_i);
      end
      repeat (idle) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= s;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    samples_sent++;
  endtask

  // random request: mostly a column-by-column scan of a keyboard whose keys
  // change a few at a time, the rest random levels and all-up/all-down noise
  task automatic make_random_sample(output kmcd_in_t s);
    int unsigned mode;
    int unsigned flips;
    int unsigned c;
    mode = $urandom_range(99, 0);
    if (mode < 65) begin
      c = scan_col;
      if ($urandom_range(99, 0) < 35) begin
        flips = $urandom_range(3, 1);
        repeat (flips) held_rows[c][$urandom_range(15, 0)] ^= 1'b1;
      end
      s.column_index = 3'(c);
      s.row_levels   = held_rows[c];
      scan_col       = (scan_col + 1) % COL_COUNT;
    end else if (mode < 88) begin
      s.column_index = 3'($urandom_range(COL_COUNT - 1, 0));
      s.row_levels   = 16'($urandom);
    end else begin
      s.column_index = 3'($urandom_range(COL_COUNT - 1, 0));
      s.row_levels   = ($urandom_range(1, 0) != 0) ? 16'hFFFF : 16'h0000;
    end
  endtask

  // output side: random backpressure, one long hold-off while the sender keeps
  // pushing requests so the block fills and stalls its input
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !hold_off_done) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_done = 1'b1;
      end else begin
        out_ready_i <= no_idle || ($urandom_range(99, 0) >= 20);
      end
    end
  end

  // event checker: every accepted event against the oldest expectation
  always @(posedge clk_i) begin
    kmcd_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      events_seen++;
      if (out_o.is_press) begin
        presses_seen++;
      end else begin
        releases_seen++;
      end
      if (expected_events.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected event keycode %0d press %0b last %0b", $time,
                 out_o.keycode, out_o.is_press, out_o.last_event);
      end else begin
        want = expected_events.pop_front();
        if (out_o.keycode !== want.keycode) begin
          mismatches++;
          $display("%0t: keycode expected %0d actual %0d", $time,
                   want.keycode, out_o.keycode);
        end
        if (out_o.is_press !== want.is_press) begin
          mismatches++;
          $display("%0t: is_press for keycode %0d expected %0b actual %0b", $time,
                   want.keycode, want.is_press, out_o.is_press);
        end
        if (out_o.last_event !== want.last_event) begin
          mismatches++;
          $display("%0t: last_event for keycode %0d expected %0b actual %0b", $time,
                   want.keycode, want.last_event, out_o.last_event);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d events still expected", $time,
               expected_events.size());
      $display("FAILURE");
      $finish;
    end
  end

  // main sequence: reset, directed table, random scan traffic, drain, verdict
  initial begin
    kmcd_in_t     s;
    scan_vector_t v;
    for (int r = 0; r < ROW_COUNT; r++) begin
      pred_pressed[r] = '0;
    end
    for (int c = 0; c < COL_COUNT; c++) begin
      held_rows[c] = 16'hFFFF;
    end
    scan_col = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: typed answers where obvious, predictor elsewhere
    for (int i = 0; i < VECTOR_COUNT; i++) begin
      v              = SCAN_VECTORS[i];
      s.column_index = v.col;
      s.row_levels   = v.levels;
      offer_sample(s, 1'b0);
      // the predictor always tracks the map, but queues only for model rows
      predict_key_events(s, v.kind == CHK_MODEL);
      if (v.kind == CHK_ONE) begin
        expected_events.push_back('{keycode: v.code, is_press: v.press, last_event: 1'b1});
      end
    end

    for (int i = 0; i < RANDOM_SAMPLES; i++) begin
      if (i == HOLD_OFF_AT) begin
        hold_off_req = 1'b1;
      end
      // a stretch with no idling on either side
      no_idle = (i >= QUIET_FROM && i < QUIET_TO);
      make_random_sample(s);
      offer_sample(s, i == DRAIN_AT);
      predict_key_events(s, 1'b1);
    end
    in_valid_i <= 1'b0;
    no_idle = 1'b0;

    while (expected_events.size() != 0) begin
      @(posedge clk_i);
    end
    // a trailing sample with no events may still be scanning
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("run covered %0d column samples and %0d key events (%0d presses, %0d releases)",
             samples_sent, events_seen, presses_seen, releases_seen);
    $display("with random backpressure, one long output hold-off and one full drain");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
